// ----- sv/dshtlm_pkg.sv -----
package dshtlm_pkg;

   localparam int FRAME_BITS    = 21;
   localparam int BITS_W        = $clog2(FRAME_BITS + 1);
   localparam int MAX_INTERVALS = 20;
   localparam int INTV_W        = $clog2(MAX_INTERVALS + 1);
   localparam int SYM_COUNT     = 4;
   localparam int STEP_W        = $clog2(SYM_COUNT);

   localparam logic [15:0] BIT_PERIOD_RESET = 16'd125;
   localparam logic [15:0] STOPPED_PERIOD   = 16'd65408;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_EDGES = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR  = 2'd2;

   // serial bit generator status toward the frame register
   typedef struct packed {
      logic busy;
      logic shift;
      logic done;
   } bitgen_status_type;

   // handoff of a finished frame to the symbol decoder
   typedef struct packed {
      logic       start;
      logic       no_edges;
      logic [1:0] motor;
   } gcr_ctl_type;

   // reverse GCR map, invalid symbols give 0
   function automatic logic [3:0] gcr_nibble(input logic [4:0] sym);
      logic [3:0] nib;
      case (sym)
         5'h09:   nib = 4'h9;
         5'h0A:   nib = 4'hA;
         5'h0B:   nib = 4'hB;
         5'h0D:   nib = 4'hD;
         5'h0E:   nib = 4'hE;
         5'h0F:   nib = 4'hF;
         5'h12:   nib = 4'h2;
         5'h13:   nib = 4'h3;
         5'h15:   nib = 4'h5;
         5'h16:   nib = 4'h6;
         5'h17:   nib = 4'h7;
         5'h19:   nib = 4'h0;
         5'h1A:   nib = 4'h8;
         5'h1B:   nib = 4'h1;
         5'h1D:   nib = 4'h4;
         5'h1E:   nib = 4'hC;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage

// ----- sv/dshtlm_bitgen.sv -----
module dshtlm_bitgen (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [15:0]                   interval,
   input  logic [15:0]                   bit_period,
   output dshtlm_pkg::bitgen_status_type status
);
   import dshtlm_pkg::*;

   logic              run_ff, run_in;
   logic [17:0]       rem_ff, rem_in;
   logic [16:0]       div_ff, div_in;
   logic [BITS_W-1:0] cnt_ff, cnt_in;
   logic [15:0]       bp_eff;
   logic              take;

   // rounded quotient by repeated subtraction, one frame bit per cycle, capped at frame size
   assign bp_eff = (bit_period == 16'd0) ? 16'd1 : bit_period;
   assign take   = run_ff && (rem_ff >= {1'b0, div_ff}) &&
                   (cnt_ff != BITS_W'(FRAME_BITS));

   always_comb begin
      run_in = run_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         rem_in = {1'b0, interval, 1'b0} + {2'b00, bp_eff};
         div_in = {bp_eff, 1'b0};
         cnt_in = '0;
      end else if (take) begin
         rem_in = rem_ff - {1'b0, div_ff};
         cnt_in = cnt_ff + 1'b1;
      end else if (run_ff) begin
         run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy  = run_ff;
   assign status.shift = take;
   assign status.done  = run_ff && !take;

endmodule

// ----- sv/dshtlm_gcr.sv -----
module dshtlm_gcr (
   input  logic                    clock,
   input  logic                    reset,
   input  dshtlm_pkg::gcr_ctl_type ctl,
   input  logic [20:0]             frame,
   output logic                    ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // status[1:0], period_us[17:2], stopped[18], decoded_word[34:19], zero pad
   output logic [39:0]             rsp_tdata,
   // motor_out[1:0]
   output logic [1:0]              rsp_tuser
);
   import dshtlm_pkg::*;

   logic              run_ff, run_in;
   logic              fin_ff, fin_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [19:0]       sym_ff, sym_in;
   logic [15:0]       word_ff, word_in;
   logic [1:0]        motor_ff, motor_in;
   logic              valid_ff, valid_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       period_ff, period_in;
   logic              stopped_ff, stopped_in;
   logic [15:0]       dword_ff, dword_in;
   logic [20:0]       nrzi;
   logic [3:0]        crc;
   logic [15:0]       period;

   assign nrzi   = frame ^ {1'b0, frame[20:1]};
   assign crc    = ~(word_ff[7:4] ^ word_ff[11:8] ^ word_ff[15:12]);
   assign period = {7'd0, word_ff[12:4]} << word_ff[15:13];
   assign ready  = !run_ff && !fin_ff && !valid_ff;

   always_comb begin
      run_in     = run_ff;
      fin_in     = 1'b0;
      step_in    = step_ff;
      sym_in     = sym_ff;
      word_in    = word_ff;
      motor_in   = motor_ff;
      valid_in   = valid_ff;
      status_in  = status_ff;
      period_in  = period_ff;
      stopped_in = stopped_ff;
      dword_in   = dword_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (ctl.start) begin
         motor_in = ctl.motor;
         if (ctl.no_edges) begin
            valid_in   = 1'b1;
            status_in  = STATUS_NO_EDGES;
            period_in  = '0;
            stopped_in = 1'b0;
            dword_in   = '0;
         end else begin
            run_in  = 1'b1;
            step_in = '0;
            sym_in  = nrzi[19:0];
         end
      end else if (run_ff) begin
         // one symbol per cycle, most significant first
         word_in = {word_ff[11:0], gcr_nibble(sym_ff[19:15])};
         sym_in  = {sym_ff[14:0], 5'd0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SYM_COUNT - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         valid_in = 1'b1;
         dword_in = word_ff;
         if (crc != word_ff[3:0]) begin
            status_in  = STATUS_CRC_ERR;
            period_in  = '0;
            stopped_in = 1'b0;
         end else begin
            status_in  = STATUS_OK;
            period_in  = period;
            stopped_in = (period == STOPPED_PERIOD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         fin_ff   <= fin_in;
         valid_ff <= valid_in;
      end
      step_ff    <= step_in;
      sym_ff     <= sym_in;
      word_ff    <= word_in;
      motor_ff   <= motor_in;
      status_ff  <= status_in;
      period_ff  <= period_in;
      stopped_ff <= stopped_in;
      dword_ff   <= dword_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, dword_ff, stopped_ff, period_ff, status_ff};
   assign rsp_tuser  = motor_ff;

endmodule

// ----- sv/bidir_dshot_telemetry_decoder.sv -----
// Decodes one bidirectional DShot eRPM telemetry reply from its edge-to-edge intervals, one
// interval per req transaction (req_tuser = motor, req_tlast = last item of the reply). Each
// interval is rounded to a bit count by a serial subtract unit that shifts one frame bit per
// cycle, so an interval item holds req_tready low until its rounded count, capped at 21, has
// been shifted in; items after a zero interval or the 20th interval skip the divider. The
// req_tlast item then pads the 21-bit frame one bit per cycle (21 minus bits so far), hands
// it to the symbol decoder (waiting if an earlier result is still unread) and returns to
// accept. The decoder works through the four GCR symbols and then checks CRC and period,
// and its result stays in the rsp register until taken while the next reply streams in.
// csr_we writes the bit period in clock cycles (reset 125, zero acts as one).
module bidir_dshot_telemetry_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // interval_cycles[15:0]
   input  logic [15:0] req_tdata,
   // motor[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], period_us[17:2], stopped[18], decoded_word[34:19], zero pad
   output logic [39:0] rsp_tdata,
   // motor_out[1:0]
   output logic [1:0]  rsp_tuser
);
   import dshtlm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_PAD  = 2'd2;
   localparam logic [1:0] ST_HAND = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [15:0]       bp_ff, bp_in;
   logic [20:0]       frame_ff, frame_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic              level_ff, level_in;
   logic [INTV_W-1:0] intv_ff, intv_in;
   logic              done_ff, done_in;
   logic [1:0]        motor_ff, motor_in;
   logic              last_ff, last_in;
   logic              accept;
   logic              shift;
   logic              bg_start;
   logic              gcr_ready;
   bitgen_status_type bg_status;
   gcr_ctl_type       gcr_ctl;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign bp_in      = csr_we ? csr_wdata : bp_ff;

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      intv_in  = intv_ff;
      done_in  = done_ff;
      motor_in = motor_ff;
      last_in  = last_ff;
      bg_start = 1'b0;
      shift    = 1'b0;
      gcr_ctl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (intv_ff == '0 && !done_ff) begin
                  motor_in = req_tuser;
               end
               if (!done_ff && req_tdata != 16'd0) begin
                  bg_start = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  if (!done_ff) begin
                     done_in = 1'b1;
                  end
                  if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_DIV: begin
            shift = bg_status.shift;
            if (bg_status.done) begin
               level_in = !level_ff;
               intv_in  = intv_ff + 1'b1;
               if (intv_ff == INTV_W'(MAX_INTERVALS - 1)) begin
                  done_in = 1'b1;
               end
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (bits_ff != BITS_W'(FRAME_BITS)) begin
               shift = 1'b1;
            end else begin
               state_in = ST_HAND;
            end
         end
         ST_HAND: begin
            if (gcr_ready) begin
               gcr_ctl.start    = 1'b1;
               gcr_ctl.no_edges = (intv_ff == '0);
               gcr_ctl.motor    = motor_ff;
               level_in = 1'b0;
               intv_in  = '0;
               done_in  = 1'b0;
               motor_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      frame_in = frame_ff;
      bits_in  = bits_ff;
      if (gcr_ctl.start) begin
         frame_in = '0;
         bits_in  = '0;
      end else if (shift) begin
         frame_in = {frame_ff[19:0], level_ff};
         if (bits_ff != BITS_W'(FRAME_BITS)) begin
            bits_in = bits_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bp_ff    <= BIT_PERIOD_RESET;
         frame_ff <= '0;
         bits_ff  <= '0;
         level_ff <= 1'b0;
         intv_ff  <= '0;
         done_ff  <= 1'b0;
         motor_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bp_ff    <= bp_in;
         frame_ff <= frame_in;
         bits_ff  <= bits_in;
         level_ff <= level_in;
         intv_ff  <= intv_in;
         done_ff  <= done_in;
         motor_ff <= motor_in;
         last_ff  <= last_in;
      end
   end

   dshtlm_bitgen u_bitgen (
      .clock      (clock),
      .reset      (reset),
      .start      (bg_start),
      .interval   (req_tdata),
      .bit_period (bp_ff),
      .status     (bg_status)
   );

   dshtlm_gcr u_gcr (
      .clock      (clock),
      .reset      (reset),
      .ctl        (gcr_ctl),
      .frame      (frame_ff),
      .ready      (gcr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // the divider only runs while no new transaction can be taken
   a_bitgen_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !bg_status.busy)
      else $error("bit generator busy while accepting");

   a_bits_sat: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BITS_W'(FRAME_BITS))
      else $error("bit count beyond frame size");

   a_no_edges_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[18:2] == '0))
      else $error("period or stopped set on failed frame");

   a_handoff: assert property (@(posedge clock) disable iff (reset)
      gcr_ctl.start |=> (state_ff == ST_IDLE && bits_ff == '0 && intv_ff == '0))
      else $error("frame state not cleared after handoff");

endmodule
